### rtl/olst_pkg.sv
// Shared types and codes for the ordered list engine.
package olst_pkg;

  // Field widths fixed by the command and result words.
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 6;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 4'd2;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DEL_KEY    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 4'd8;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Command word.
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } out_word_t;

  // Movement control broadcast to every cell of the chain.
  typedef struct packed {
    logic shl;  // take the right neighbor's value
    logic shr;  // take the left neighbor's value
  } cell_ctl_t;

endpackage

### rtl/olst_cell.sv
// One storage cell of the list chain, holding a single entry.
module olst_cell (
  input  logic                             clk,
  input  olst_pkg::cell_ctl_t              ctl,
  input  logic                             we,
  input  logic signed [olst_pkg::VAL_W-1:0] wdata,
  input  logic signed [olst_pkg::VAL_W-1:0] left_in,
  input  logic signed [olst_pkg::VAL_W-1:0] right_in,
  output logic signed [olst_pkg::VAL_W-1:0] q
);
  import olst_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  // A direct write wins over a shift; otherwise the cell moves or holds.
  always_comb begin
    if (we) begin
      val_nxt = wdata;
    end else if (ctl.shl) begin
      val_nxt = right_in;
    end else if (ctl.shr) begin
      val_nxt = left_in;
    end else begin
      val_nxt = val_r;
    end
  end

  // Entry storage needs no reset; the count says which cells are live.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

### rtl/ordered_list_engine.sv
// Top level of the ordered list engine: control sequencer and chain of cells.
//
//   port group | direction | handshake          | word
//   in_*       | input     | in_valid/in_stall   | olst_pkg::in_word_t  (cmd, key, value)
//   out_*      | output    | out_valid/out_stall | olst_pkg::out_word_t (status, position,
//              |           |                     |   entry_value, last)
//
// Insert or delete at either end updates the chain in the accept cycle; the
// status word is then registered from the finish state. Key commands rotate
// the whole chain once, one entry per cycle through cell 0; an insert by key
// adds a step to place the new entry, and a dump step waits while out_stall
// holds the output register. Dump sends one word per rotation step, the last
// one flagged last. Every word waits while out_stall holds the output register.
// Reset clears the entry count and control; cell contents are not reset.
// One command is worked on at a time; in_stall is high while it is busy.
module ordered_list_engine #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  olst_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output olst_pkg::out_word_t out_data
);
  import olst_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic [CW-1:0]           j_r, j_nxt;
  logic                    found_r, found_nxt;
  logic                    pend_r, pend_nxt;
  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic [STAT_W-1:0]       st_r, st_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_r, out_nxt;

  cell_ctl_t               ctl;
  logic                    wr;
  logic [IW-1:0]           wpos;
  logic signed [VAL_W-1:0] wdata;
  logic [CAPACITY-1:0]     we;
  logic signed [VAL_W-1:0] cell_q [CAPACITY];
  logic signed [VAL_W-1:0] head;
  logic                    emit_ok;
  logic                    hit;
  logic                    app;
  logic                    advance;

  assign head    = cell_q[0];
  assign emit_ok = !out_valid_r || !out_stall;
  assign hit     = !found_r && (head == key_r);

  // Sequencer: decodes a command, then steers the chain one step per cycle unless a dump waits on out_stall.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    j_nxt         = j_r;
    found_nxt     = found_r;
    pend_nxt      = pend_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    st_nxt        = st_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ctl           = '0;
    wr            = 1'b0;
    wpos          = '0;
    wdata         = head;
    app           = 1'b0;
    advance       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          key_nxt   = in_data.key;
          value_nxt = in_data.value;
          st_nxt    = ST_DONE;
          pos_nxt   = '0;
          state_nxt = S_FIN;
          case (in_data.cmd)
            CMD_INS_FRONT: begin
              if (count_r == CAP_CNT) begin
                st_nxt = ST_FULL;
              end else begin
                ctl.shr   = 1'b1;
                wr        = 1'b1;
                wpos      = '0;
                wdata     = in_data.value;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_INS_BACK: begin
              if (count_r == CAP_CNT) begin
                st_nxt = ST_FULL;
              end else begin
                wr        = 1'b1;
                wpos      = IW'(count_r);
                wdata     = in_data.value;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_INS_BEFORE, CMD_INS_AFTER, CMD_DEL_KEY, CMD_SEARCH, CMD_DUMP: begin
              if ((in_data.cmd == CMD_INS_BEFORE || in_data.cmd == CMD_INS_AFTER) &&
                  count_r == CAP_CNT) begin
                st_nxt = ST_FULL;
              end else if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_WALK;
                rem_nxt   = count_r;
                j_nxt     = '0;
                found_nxt = 1'b0;
                pend_nxt  = 1'b0;
              end
            end
            CMD_DEL_FRONT: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                ctl.shl   = 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            CMD_DEL_BACK: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            default: begin
              st_nxt = ST_DONE;
            end
          endcase
        end
      end

      S_WALK: begin
        advance = pend_r || (cmd_r != CMD_DUMP) || emit_ok;
        if (pend_r) begin
          // Second half of an insert after the key: place the new entry.
          app       = 1'b1;
          wdata     = value_r;
          count_nxt = count_r + 1'b1;
          pend_nxt  = 1'b0;
        end else if (advance) begin
          case (cmd_r)
            CMD_INS_BEFORE: begin
              if (hit) begin
                // Queue the new entry ahead of the matching head.
                app       = 1'b1;
                wdata     = value_r;
                count_nxt = count_r + 1'b1;
                found_nxt = 1'b1;
              end else begin
                ctl.shl = 1'b1;
                app     = 1'b1;
                rem_nxt = rem_r - 1'b1;
                j_nxt   = j_r + 1'b1;
              end
            end
            CMD_INS_AFTER: begin
              ctl.shl = 1'b1;
              app     = 1'b1;
              rem_nxt = rem_r - 1'b1;
              j_nxt   = j_r + 1'b1;
              if (hit) begin
                found_nxt = 1'b1;
                pend_nxt  = 1'b1;
              end
            end
            CMD_DEL_KEY: begin
              ctl.shl = 1'b1;
              rem_nxt = rem_r - 1'b1;
              j_nxt   = j_r + 1'b1;
              if (hit) begin
                // Drop the head instead of recirculating it.
                found_nxt = 1'b1;
                count_nxt = count_r - 1'b1;
              end else begin
                app = 1'b1;
              end
            end
            CMD_SEARCH: begin
              ctl.shl = 1'b1;
              app     = 1'b1;
              rem_nxt = rem_r - 1'b1;
              j_nxt   = j_r + 1'b1;
              if (hit) begin
                found_nxt = 1'b1;
                pos_nxt   = POS_W'({1'b0, j_r} + 1'b1);
              end
            end
            default: begin
              // Dump: send the head and recirculate it.
              ctl.shl             = 1'b1;
              app                 = 1'b1;
              rem_nxt             = rem_r - 1'b1;
              j_nxt               = j_r + 1'b1;
              out_valid_nxt       = 1'b1;
              out_nxt.status      = ST_DONE;
              out_nxt.position    = POS_W'({1'b0, j_r} + 1'b1);
              out_nxt.entry_value = head;
              out_nxt.last        = (rem_r == CW'(1));
            end
          endcase
        end

        // Appended words land just past the live entries after the shift.
        if (app) begin
          wr   = 1'b1;
          wpos = IW'(count_nxt - 1'b1);
        end

        if (advance && rem_nxt == '0 && !pend_nxt) begin
          state_nxt = (cmd_r == CMD_DUMP) ? S_IDLE : S_FIN;
          st_nxt    = found_nxt ? ST_DONE : ST_MISS;
        end
      end

      S_FIN: begin
        if (emit_ok) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = st_r;
          out_nxt.position    = pos_r;
          out_nxt.entry_value = '0;
          out_nxt.last        = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      j_r         <= '0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      j_r         <= j_nxt;
      found_r     <= found_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    value_r <= value_nxt;
    st_r    <= st_nxt;
    pos_r   <= pos_nxt;
    out_r   <= out_nxt;
  end

  // Chain of cells; cell 0 is the front of the list.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;

    assign we[i] = wr && (wpos == IW'(i));

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_q[i+1];
    end

    olst_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .we       (we[i]),
      .wdata    (wdata),
      .left_in  (left_v),
      .right_in (right_v),
      .q        (cell_q[i])
    );
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The entry count never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count exceeds capacity");

  // A rotation always has work left while it runs.
  a_walk_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (rem_r != '0 || pend_r))
    else $error("rotation running with nothing left");

  // Unvisited entries are always among the live ones.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (rem_r <= count_r))
    else $error("rotation remainder exceeds entry count");

endmodule

### sim/ordered_list_engine_tb.sv
// Self-checking testbench for the ordered list engine, with directed and random command streams.
`timescale 1ns / 100ps

module ordered_list_engine_tb;
  import olst_pkg::*;

  localparam int unsigned CAPACITY       = 32;
  localparam time         CLK_PERIOD     = 10ns;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned RANDOM_ITEMS   = 420;
  localparam int unsigned SETTLE_CYCLES  = 2 * CAPACITY + 16;
  localparam int unsigned TIMEOUT_CYCLES = 500_000;
  localparam int unsigned FILL_RUN       = CAPACITY + 2;
  localparam logic [CMD_W-1:0] CMD_LAST_CODE = {CMD_W{1'b1}};

  // One queued command word and whether the sender first waits for all results.
  typedef struct {
    in_word_t word;
    bit       drain;
  } cmd_item_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  cmd_item_t cmd_backlog[$];
  out_word_t pending_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;

  // Shadow copy of the list as the block should hold it.
  logic signed [VAL_W-1:0] model_entries [CAPACITY];
  int unsigned             list_len = 0;

  // Values that recur often so that key commands hit, plus the extremes.
  logic signed [VAL_W-1:0] operand_pool [8] = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF,
                                                 32'sh8000_0000, 32'sd5, 32'sd42, -32'sd100};

  ordered_list_engine #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Index of the first entry equal to the key, or the list length on a miss.
  function automatic int unsigned find_key(logic signed [VAL_W-1:0] k);
    for (int unsigned i = 0; i < list_len; i++) begin
      if (model_entries[i] == k) return i;
    end
    return list_len;
  endfunction

  function automatic void insert_entry(int unsigned idx, logic signed [VAL_W-1:0] v);
    for (int unsigned i = list_len; i > idx; i--) model_entries[i] = model_entries[i - 1];
    model_entries[idx] = v;
    list_len++;
  endfunction

  function automatic void remove_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < list_len; i++) model_entries[i] = model_entries[i + 1];
    list_len--;
  endfunction

  function automatic void push_result(logic [STAT_W-1:0] st, int unsigned pos,
                                      logic signed [VAL_W-1:0] v, logic lst);
    out_word_t r;
    r.status      = st;
    r.position    = POS_W'(pos);
    r.entry_value = v;
    r.last        = lst;
    pending_results.push_back(r);
  endfunction

  // Applies one accepted command to the shadow list and queues its results.
  function automatic void apply_command(in_word_t w);
    int unsigned       hit;
    int unsigned       pos;
    logic [STAT_W-1:0] st;
    st  = ST_DONE;
    pos = 0;
    hit = find_key(w.key);
    case (w.cmd)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_BEFORE, CMD_INS_AFTER: begin
        if (list_len >= CAPACITY) st = ST_FULL;
        else if (w.cmd == CMD_INS_FRONT) insert_entry(0, w.value);
        else if (w.cmd == CMD_INS_BACK) insert_entry(list_len, w.value);
        else if (list_len == 0) st = ST_EMPTY;
        else if (hit == list_len) st = ST_MISS;
        else insert_entry((w.cmd == CMD_INS_BEFORE) ? hit : hit + 1, w.value);
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (list_len == 0) st = ST_EMPTY;
        else remove_entry((w.cmd == CMD_DEL_FRONT) ? 0 : list_len - 1);
      end
      CMD_DEL_KEY, CMD_SEARCH: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (hit == list_len) st = ST_MISS;
        else if (w.cmd == CMD_DEL_KEY) remove_entry(hit);
        else pos = hit + 1;
      end
      CMD_DUMP: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int unsigned i = 0; i < list_len; i++)
            push_result(ST_DONE, i + 1, model_entries[i], (i + 1 == list_len));
          return;
        end
      end
      default: ;
    endcase
    push_result(st, pos, '0, 1'b1);
  endfunction

  function automatic void queue_command(logic [CMD_W-1:0] c, logic signed [VAL_W-1:0] k,
                                        logic signed [VAL_W-1:0] v, bit drain = 1'b0);
    cmd_item_t it;
    it.word.cmd   = c;
    it.word.key   = k;
    it.word.value = v;
    it.drain      = drain;
    cmd_backlog.push_back(it);
  endfunction

  // Mostly values from the pool, sometimes a fully random word.
  function automatic logic signed [VAL_W-1:0] pick_operand();
    if ($urandom_range(0, 9) < 3) return $urandom;
    return operand_pool[$urandom_range(0, 7)];
  endfunction

  task automatic report_mismatch(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    mismatch_cnt++;
  endtask

  // Driver: presents queued words, idles at random and holds a stalled word.
  always @(posedge clk) begin : driver
    cmd_item_t  nxt;
    int unsigned send_idle;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      send_idle = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(in_data);
        n_accepted++;
        send_idle = ((n_accepted / 50) % 4 == 3) ? 0 : $urandom_range(0, 4);
      end
      if (!in_valid || !in_stall) begin
        if (send_idle > 0) begin
          in_valid <= 1'b0;
          send_idle--;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].drain && pending_results.size() != 0)) begin
          nxt = cmd_backlog.pop_front();
          in_data  <= nxt.word;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls at random and checks each result word against the oldest expectation.
  always @(posedge clk) begin : monitor
    out_word_t   want;
    int unsigned recv_idle;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_idle = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %p", $time, out_data);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", VAL_W'(want.status), VAL_W'(out_data.status));
          if (out_data.position !== want.position)
            report_mismatch("position", VAL_W'(want.position), VAL_W'(out_data.position));
          if (out_data.entry_value !== want.entry_value)
            report_mismatch("entry_value", want.entry_value, out_data.entry_value);
          if (out_data.last !== want.last)
            report_mismatch("last", VAL_W'(want.last), VAL_W'(out_data.last));
        end
        recv_idle = ((n_results / 60) % 4 == 1) ? 0 : $urandom_range(0, 4);
      end
      if (recv_idle > 0) begin
        out_stall <= 1'b1;
        recv_idle--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int unsigned n_random;
    int unsigned run_len;
    int unsigned pick;
    bit          first_seq;

    // Directed part: empty list cases, extremes, every command, misses and unknown codes.
    queue_command(CMD_DUMP, '0, '0);
    queue_command(CMD_DEL_FRONT, '0, '0);
    queue_command(CMD_DEL_BACK, '0, '0);
    queue_command(CMD_DEL_KEY, 32'sd0, '0);
    queue_command(CMD_SEARCH, 32'sd0, '0);
    queue_command(CMD_INS_BEFORE, 32'sd0, 32'sd1);
    queue_command(CMD_INS_AFTER, 32'sd0, 32'sd1);
    queue_command(CMD_INS_FRONT, '0, 32'sh7FFF_FFFF);
    queue_command(CMD_INS_BACK, '0, 32'sh8000_0000);
    queue_command(CMD_INS_FRONT, '0, 32'sd0);
    queue_command(CMD_INS_BACK, '1, -32'sd1);
    queue_command(CMD_SEARCH, 32'sh8000_0000, '1);
    queue_command(CMD_SEARCH, 32'sd12345, '0);
    queue_command(CMD_INS_BEFORE, 32'sd0, 32'sh5555_5555);
    queue_command(CMD_INS_AFTER, -32'sd1, 32'shAAAA_AAAA);
    queue_command(CMD_INS_BEFORE, 32'sd777, 32'sd3);
    queue_command(CMD_DEL_KEY, 32'sd777, '0);
    queue_command(CMD_DEL_KEY, 32'sh7FFF_FFFF, '0);
    queue_command(CMD_DUMP, '0, '0);
    queue_command(CMD_DUMP + 1'b1, '1, '1);
    queue_command(CMD_LAST_CODE, '0, '0);
    queue_command(CMD_DEL_FRONT, '0, '0);
    queue_command(CMD_DEL_BACK, '0, '0);
    queue_command(CMD_DUMP, '0, '0);

    // Random part: runs that fill the list to the top, runs that empty it, and mixed runs.
    n_random  = 0;
    first_seq = 1'b1;
    while (n_random < RANDOM_ITEMS) begin
      pick = first_seq ? 0 : $urandom_range(0, 5);
      if (pick == 0) begin
        for (int unsigned i = 0; i < FILL_RUN; i++)
          queue_command($urandom_range(0, 1) ? CMD_INS_FRONT : CMD_INS_BACK, pick_operand(),
                        pick_operand(), (i == 0) && (first_seq || $urandom_range(0, 3) == 0));
        for (int unsigned i = 0; i < 4; i++)
          queue_command(CMD_W'($urandom_range(CMD_INS_FRONT, CMD_INS_AFTER)), pick_operand(),
                        pick_operand());
        queue_command(CMD_DUMP, pick_operand(), pick_operand());
        n_random += FILL_RUN + 5;
      end else if (pick == 1) begin
        for (int unsigned i = 0; i < FILL_RUN; i++)
          queue_command($urandom_range(0, 1) ? CMD_DEL_FRONT : CMD_DEL_BACK, pick_operand(),
                        pick_operand(), (i == 0) && ($urandom_range(0, 3) == 0));
        queue_command(CMD_W'($urandom_range(CMD_INS_BEFORE, CMD_SEARCH)), pick_operand(),
                      pick_operand());
        queue_command(CMD_DUMP, pick_operand(), pick_operand());
        n_random += FILL_RUN + 2;
      end else begin
        run_len = $urandom_range(15, 25);
        for (int unsigned i = 0; i < run_len; i++) begin
          pick = $urandom_range(0, 19);
          queue_command((pick < 18) ? CMD_W'(pick % (CMD_DUMP + 1)) :
                        CMD_W'($urandom_range(CMD_DUMP + 1, CMD_LAST_CODE)),
                        pick_operand(), pick_operand(), (i == 0) && ($urandom_range(0, 3) == 0));
        end
        n_random += run_len;
      end
      first_seq = 1'b0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every word to be accepted and every result to arrive, then let the block settle.
    @(posedge clk);
    while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d results still expected", $time, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
